FILE: sv/tirv_pkg.sv
// Shared types and constants for the tiered ingress rule verdict block.
// No dependencies; used by tirv_slot_decode, tirv_verdict and the top level.
package tirv_pkg;

    localparam int RULE_SLOTS = 24;
    localparam int SLOT_CNT_W = $clog2(RULE_SLOTS + 1);

    localparam logic [16:0] PRIO_NONE   = 17'd65536;
    localparam logic [16:0] ADMIN_LIMIT = 17'd1000;
    localparam logic [7:0]  PROTO_ANY      = 8'd254;
    localparam logic [7:0]  PROTO_RESERVED = 8'd255;

    // reciprocal of ten, scaled by 2^23; exact quotient for 20-bit values
    localparam logic [19:0] RECIP_TEN = 20'd838861;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [3:0] ACT_DENY  = 4'd0;
    localparam logic [3:0] ACT_ALLOW = 4'd1;
    localparam logic [3:0] ACT_PASS  = 4'd2;

    localparam logic [2:0] TIER_ADMIN     = 3'd0;
    localparam logic [2:0] TIER_NAMESPACE = 3'd1;
    localparam logic [2:0] TIER_BASELINE  = 3'd2;
    localparam logic [2:0] TIER_DEFAULT   = 3'd3;
    localparam logic [2:0] TIER_NONE      = 3'd4;

    localparam logic [1:0] POD_APPLIED       = 2'd0;
    localparam logic [1:0] POD_DEFAULT_ALLOW = 2'd1;
    localparam logic [1:0] POD_DEFAULT_DENY  = 2'd2;

    // one input word, as unpacked from tdata plus tlast
    typedef struct packed {
        logic [7:0]  flow_protocol;
        logic [15:0] flow_dest_port;
        logic        cluster_list_found;
        logic [7:0]  cluster_rule_protocol;
        logic [19:0] cluster_rule_priority;
        logic [15:0] cluster_rule_start_port;
        logic [15:0] cluster_rule_end_port;
        logic        namespace_list_found;
        logic [7:0]  namespace_rule_protocol;
        logic [15:0] namespace_rule_start_port;
        logic [15:0] namespace_rule_end_port;
        logic        last_slot;
    } slot_t;

    // decoded slot handed to the verdict stage
    typedef struct packed {
        logic        c_found;
        logic        c_hit;
        logic [16:0] c_prio;
        logic [3:0]  c_act;
        logic        n_found;
        logic        n_reserved;
        logic        n_hit;
        logic        last;
    } slot_dec_t;

endpackage

FILE: sv/tirv_slot_decode.sv
// Rule slot decoder: port/protocol match for both entries and the split of
// the cluster priority field into priority and action. Uses tirv_pkg.
module tirv_slot_decode (
    input  tirv_pkg::slot_t     slot,
    output tirv_pkg::slot_dec_t dec
);

    logic [39:0] prod;
    logic [16:0] quot;
    logic [19:0] quot_x10;
    logic [19:0] rem;
    logic        c_port_hit;
    logic        n_port_hit;

    // divide by ten through the reciprocal, remainder by shift-add back
    assign prod     = {20'd0, slot.cluster_rule_priority} * {20'd0, tirv_pkg::RECIP_TEN};
    assign quot     = prod[tirv_pkg::RECIP_SHIFT +: 17];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem      = slot.cluster_rule_priority - quot_x10;

    assign c_port_hit = (slot.cluster_rule_start_port == 16'd0)
        || (slot.flow_dest_port == slot.cluster_rule_start_port)
        || ((slot.cluster_rule_end_port != 16'd0)
            && (slot.flow_dest_port >= slot.cluster_rule_start_port)
            && (slot.flow_dest_port <= slot.cluster_rule_end_port));

    assign n_port_hit = (slot.namespace_rule_start_port == 16'd0)
        || (slot.flow_dest_port == slot.namespace_rule_start_port)
        || ((slot.flow_dest_port > slot.namespace_rule_start_port)
            && (slot.flow_dest_port <= slot.namespace_rule_end_port));

    always_comb
    begin
        dec.c_found    = slot.cluster_list_found;
        dec.c_hit      = (slot.cluster_rule_protocol == tirv_pkg::PROTO_ANY)
                         || ((slot.cluster_rule_protocol == slot.flow_protocol) && c_port_hit);
        dec.c_prio     = quot;
        dec.c_act      = rem[3:0];
        dec.n_found    = slot.namespace_list_found;
        dec.n_reserved = (slot.namespace_rule_protocol == tirv_pkg::PROTO_RESERVED);
        dec.n_hit      = ((slot.namespace_rule_protocol == tirv_pkg::PROTO_ANY)
                          || (slot.namespace_rule_protocol == slot.flow_protocol))
                         && n_port_hit;
        dec.last       = slot.last_slot;
    end

endmodule

FILE: sv/tirv_verdict.sv
// Per-flow running minima, namespace first match, pod state register and
// the verdict output register. Uses tirv_pkg; fed by tirv_slot_decode.
module tirv_verdict (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  logic                go,
    input  tirv_pkg::slot_dec_t dec,
    output logic                out_free,
    output logic                out_vld,
    input  logic                out_rdy,
    output logic                out_allow,
    output logic [2:0]          out_tier
);

    logic [1:0]                      pod_reg;
    logic [16:0]                     adm_p_reg,  adm_p_next;
    logic [3:0]                      adm_a_reg,  adm_a_next;
    logic [16:0]                     base_p_reg, base_p_next;
    logic [3:0]                      base_a_reg, base_a_next;
    logic                            ns_dec_reg, ns_dec_next;
    logic                            ns_allow_reg, ns_allow_next;
    logic [tirv_pkg::SLOT_CNT_W-1:0] cnt_reg,    cnt_next;
    logic                            vld_reg,    vld_next;
    logic                            allow_reg,  allow_next;
    logic [2:0]                      tier_reg,   tier_next;
    logic                            in_bound;
    logic                            c_en;
    logic                            n_en;
    logic                            v_allow;
    logic [2:0]                      v_tier;

    assign out_free  = !vld_reg || out_rdy;
    assign out_vld   = vld_reg;
    assign out_allow = allow_reg;
    assign out_tier  = tier_reg;

    assign in_bound = (cnt_reg < tirv_pkg::SLOT_CNT_W'(tirv_pkg::RULE_SLOTS));
    assign c_en     = in_bound && dec.c_found && dec.c_hit;
    assign n_en     = in_bound && dec.n_found && !ns_dec_reg;

    // state after this slot is folded in
    always_comb
    begin
        adm_p_next    = adm_p_reg;
        adm_a_next    = adm_a_reg;
        base_p_next   = base_p_reg;
        base_a_next   = base_a_reg;
        ns_dec_next   = ns_dec_reg;
        ns_allow_next = ns_allow_reg;
        cnt_next      = cnt_reg;
        if (in_bound)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (c_en && ((dec.c_prio < adm_p_reg)
                     || ((dec.c_prio == adm_p_reg) && (dec.c_act < adm_a_reg))))
        begin
            adm_p_next = dec.c_prio;
            adm_a_next = dec.c_act;
        end
        if (c_en && (dec.c_prio > tirv_pkg::ADMIN_LIMIT)
            && ((dec.c_prio < base_p_reg)
                || ((dec.c_prio == base_p_reg) && (dec.c_act < base_a_reg))))
        begin
            base_p_next = dec.c_prio;
            base_a_next = dec.c_act;
        end
        if (n_en && dec.n_reserved)
        begin
            ns_dec_next   = 1'b1;
            ns_allow_next = 1'b0;
        end
        else if (n_en && dec.n_hit)
        begin
            ns_dec_next   = 1'b1;
            ns_allow_next = 1'b1;
        end
    end

    // tiered decision on the updated state
    always_comb
    begin
        v_allow = 1'b0;
        v_tier  = tirv_pkg::TIER_NONE;
        if ((adm_p_next <= tirv_pkg::ADMIN_LIMIT) && (adm_a_next == tirv_pkg::ACT_DENY))
        begin
            v_tier = tirv_pkg::TIER_ADMIN;
        end
        else if ((adm_p_next <= tirv_pkg::ADMIN_LIMIT) && (adm_a_next == tirv_pkg::ACT_ALLOW))
        begin
            v_allow = 1'b1;
            v_tier  = tirv_pkg::TIER_ADMIN;
        end
        else if (dec.n_found)
        begin
            v_allow = ns_dec_next && ns_allow_next;
            v_tier  = tirv_pkg::TIER_NAMESPACE;
        end
        else if (pod_reg == tirv_pkg::POD_APPLIED)
        begin
            v_tier = tirv_pkg::TIER_NAMESPACE;
        end
        else if (base_a_next == tirv_pkg::ACT_DENY)
        begin
            v_tier = tirv_pkg::TIER_BASELINE;
        end
        else if (base_a_next == tirv_pkg::ACT_ALLOW)
        begin
            v_allow = 1'b1;
            v_tier  = tirv_pkg::TIER_BASELINE;
        end
        else if (base_a_next == tirv_pkg::ACT_PASS)
        begin
            case (pod_reg)
                tirv_pkg::POD_DEFAULT_ALLOW:
                begin
                    v_allow = 1'b1;
                    v_tier  = tirv_pkg::TIER_DEFAULT;
                end
                tirv_pkg::POD_DEFAULT_DENY:
                begin
                    v_tier = tirv_pkg::TIER_DEFAULT;
                end
                default:
                begin
                    v_tier = tirv_pkg::TIER_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        vld_next   = vld_reg;
        allow_next = allow_reg;
        tier_next  = tier_reg;
        if (go && dec.last)
        begin
            vld_next   = 1'b1;
            allow_next = v_allow;
            tier_next  = v_tier;
        end
        else if (out_rdy)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pod_reg      <= tirv_pkg::POD_DEFAULT_ALLOW;
            adm_p_reg    <= tirv_pkg::PRIO_NONE;
            adm_a_reg    <= tirv_pkg::ACT_PASS;
            base_p_reg   <= tirv_pkg::PRIO_NONE;
            base_a_reg   <= tirv_pkg::ACT_PASS;
            ns_dec_reg   <= 1'b0;
            ns_allow_reg <= 1'b0;
            cnt_reg      <= '0;
            vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                pod_reg <= cfg_wr_data;
            end
            vld_reg <= vld_next;
            if (go && dec.last)
            begin
                // flow done: clear for the next one
                adm_p_reg    <= tirv_pkg::PRIO_NONE;
                adm_a_reg    <= tirv_pkg::ACT_PASS;
                base_p_reg   <= tirv_pkg::PRIO_NONE;
                base_a_reg   <= tirv_pkg::ACT_PASS;
                ns_dec_reg   <= 1'b0;
                ns_allow_reg <= 1'b0;
                cnt_reg      <= '0;
            end
            else if (go)
            begin
                adm_p_reg    <= adm_p_next;
                adm_a_reg    <= adm_a_next;
                base_p_reg   <= base_p_next;
                base_a_reg   <= base_a_next;
                ns_dec_reg   <= ns_dec_next;
                ns_allow_reg <= ns_allow_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        allow_reg <= allow_next;
        tier_reg  <= tier_next;
    end

endmodule

FILE: sv/tiered_ingress_rule_verdict.sv
// Top level of the tiered ingress rule verdict block: input register,
// decode register and handshake. Uses tirv_pkg, tirv_slot_decode, tirv_verdict.
//
// Usage: one flow is sent as a run of words on s_axis, one rule slot per
// word (a cluster entry and a namespace entry plus the flow's protocol and
// port); s_axis_tlast marks the final slot. Only the final slot gives a
// result word on m_axis: the allow bit and the deciding tier. Slots past the
// 24th of a flow are ignored, but a final slot past the bound still gives
// the verdict. The user writes the pod state register through cfg_wr_en and
// cfg_wr_data only while no flow is in flight; the block does not enforce it.
// Throughput: one slot per cycle, except that a final slot waits in the
// decode register while the result register is still held. The final slot
// is taken into the input register, then the decode register, then the
// result register; the divide-by-ten multiplier sits in the decode step.
// Reset clears all flow state, empties the pipeline and sets the pod state
// to default allow. When m_axis_tready is low, the result register holds;
// slots that are not final keep flowing into the flow state, and intake
// stops only once a further final slot reaches the decode register.
module tiered_ingress_rule_verdict (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // flow_protocol, flow_dest_port, cluster_list_found, cluster_rule_protocol,
    // cluster_rule_priority, cluster_rule_start_port, cluster_rule_end_port,
    // namespace_list_found, namespace_rule_protocol, namespace_rule_start_port,
    // namespace_rule_end_port, zero fill (low bit first)
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // allow, decided_tier, zero fill (low bit first)
    output logic [7:0]   m_axis_tdata
);

    tirv_pkg::slot_t     slot_in;
    tirv_pkg::slot_t     s0_reg;
    logic                s0_vld_reg;
    tirv_pkg::slot_dec_t dec;
    tirv_pkg::slot_dec_t s1_reg;
    logic                s1_vld_reg;
    logic                out_free;
    logic                s1_go;
    logic                s0_move;
    logic                s_accept;
    logic                v_allow;
    logic [2:0]          v_tier;

    always_comb
    begin
        slot_in.flow_protocol             = s_axis_tdata[7:0];
        slot_in.flow_dest_port            = s_axis_tdata[23:8];
        slot_in.cluster_list_found        = s_axis_tdata[24];
        slot_in.cluster_rule_protocol     = s_axis_tdata[32:25];
        slot_in.cluster_rule_priority     = s_axis_tdata[52:33];
        slot_in.cluster_rule_start_port   = s_axis_tdata[68:53];
        slot_in.cluster_rule_end_port     = s_axis_tdata[84:69];
        slot_in.namespace_list_found      = s_axis_tdata[85];
        slot_in.namespace_rule_protocol   = s_axis_tdata[93:86];
        slot_in.namespace_rule_start_port = s_axis_tdata[109:94];
        slot_in.namespace_rule_end_port   = s_axis_tdata[125:110];
        slot_in.last_slot                 = s_axis_tlast;
    end

    // a final slot needs the result register free; others never wait
    assign s1_go         = s1_vld_reg && (!s1_reg.last || out_free);
    assign s0_move       = s0_vld_reg && (!s1_vld_reg || s1_go);
    assign s_axis_tready = !s0_vld_reg || s0_move;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    tirv_slot_decode u_decode (
        .slot (s0_reg),
        .dec  (dec)
    );

    tirv_verdict u_verdict (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (s1_go),
        .dec         (s1_reg),
        .out_free    (out_free),
        .out_vld     (m_axis_tvalid),
        .out_rdy     (m_axis_tready),
        .out_allow   (v_allow),
        .out_tier    (v_tier)
    );

    assign m_axis_tdata = {4'b0000, v_tier, v_allow};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                s0_vld_reg <= 1'b1;
            end
            else if (s0_move)
            begin
                s0_vld_reg <= 1'b0;
            end
            if (s0_move)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s0_reg <= slot_in;
        end
        if (s0_move)
        begin
            s1_reg <= dec;
        end
    end

endmodule

FILE: bench/tb_tiered_ingress_rule_verdict.sv
// Self-checking bench for tiered_ingress_rule_verdict: flows of rule slots go in
// on s_axis and verdict words are checked against a local predictor.
// Depends on tirv_pkg and the tiered_ingress_rule_verdict RTL.
module tb_tiered_ingress_rule_verdict;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 50;

    typedef struct packed {
        logic       allow;
        logic [2:0] tier;
    } verdict_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_wr_data = 2'd0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    // stimulus and scoreboard
    tirv_pkg::slot_t slot_queue[$];
    verdict_t        verdict_q[$];
    tirv_pkg::slot_t cur_slot;
    bit       in_fire = 1'b0;
    bit       out_fire = 1'b0;
    int       fail_count = 0;
    int       idle_cycles = 0;
    int       drv_gap = 0;
    int       rcv_gap = 0;
    int       hold_left = 0;
    int       hold_requests = 0;
    int       holds_served = 0;
    bit       sender_gaps_on = 1'b1;
    bit       receiver_gaps_on = 1'b1;

    // predicted flow state
    logic [1:0]  pod_mode = tirv_pkg::POD_DEFAULT_ALLOW;
    logic [16:0] admin_prio = tirv_pkg::PRIO_NONE;
    logic [3:0]  admin_act = tirv_pkg::ACT_PASS;
    logic [16:0] base_prio = tirv_pkg::PRIO_NONE;
    logic [3:0]  base_act = tirv_pkg::ACT_PASS;
    logic        ns_decided = 1'b0;
    logic        ns_allows = 1'b0;
    int          slot_cnt = 0;

    tiered_ingress_rule_verdict u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int gap_draw(bit on);
        return on ? $urandom_range(0, 5) : 0;
    endfunction

    function automatic logic [127:0] pack_slot(tirv_pkg::slot_t s);
        return {2'b00, s.namespace_rule_end_port, s.namespace_rule_start_port,
                s.namespace_rule_protocol, s.namespace_list_found,
                s.cluster_rule_end_port, s.cluster_rule_start_port,
                s.cluster_rule_priority, s.cluster_rule_protocol,
                s.cluster_list_found, s.flow_dest_port, s.flow_protocol};
    endfunction

    // running minimum over (priority, action); returns 1 when the entry wins
    function automatic bit beats(logic [16:0] prio, logic [3:0] act,
                                 logic [16:0] best_prio, logic [3:0] best_act);
        return (prio < best_prio) || (prio == best_prio && act < best_act);
    endfunction

    function automatic void clear_flow_state();
        admin_prio = tirv_pkg::PRIO_NONE;
        admin_act  = tirv_pkg::ACT_PASS;
        base_prio  = tirv_pkg::PRIO_NONE;
        base_act   = tirv_pkg::ACT_PASS;
        ns_decided = 1'b0;
        ns_allows  = 1'b0;
        slot_cnt   = 0;
    endfunction

    function automatic verdict_t tier_verdict(logic ns_found);
        verdict_t v;
        v.allow = 1'b0;
        v.tier  = tirv_pkg::TIER_NONE;
        if (admin_prio <= tirv_pkg::ADMIN_LIMIT && admin_act == tirv_pkg::ACT_DENY)
            v.tier = tirv_pkg::TIER_ADMIN;
        else if (admin_prio <= tirv_pkg::ADMIN_LIMIT && admin_act == tirv_pkg::ACT_ALLOW)
        begin
            v.allow = 1'b1;
            v.tier  = tirv_pkg::TIER_ADMIN;
        end
        else if (ns_found)
        begin
            v.allow = ns_decided && ns_allows;
            v.tier  = tirv_pkg::TIER_NAMESPACE;
        end
        else if (pod_mode == tirv_pkg::POD_APPLIED)
            v.tier = tirv_pkg::TIER_NAMESPACE;
        else if (base_act == tirv_pkg::ACT_DENY)
            v.tier = tirv_pkg::TIER_BASELINE;
        else if (base_act == tirv_pkg::ACT_ALLOW)
        begin
            v.allow = 1'b1;
            v.tier  = tirv_pkg::TIER_BASELINE;
        end
        else if (base_act == tirv_pkg::ACT_PASS && pod_mode == tirv_pkg::POD_DEFAULT_ALLOW)
        begin
            v.allow = 1'b1;
            v.tier  = tirv_pkg::TIER_DEFAULT;
        end
        else if (base_act == tirv_pkg::ACT_PASS && pod_mode == tirv_pkg::POD_DEFAULT_DENY)
            v.tier = tirv_pkg::TIER_DEFAULT;
        return v;
    endfunction

    function automatic void fold_rule_slot(tirv_pkg::slot_t s);
        logic [16:0] prio;
        logic [3:0]  act;
        logic        c_hit;
        logic        n_port_hit;
        if (slot_cnt < tirv_pkg::RULE_SLOTS)
        begin
            if (s.cluster_list_found)
            begin
                prio  = 17'(s.cluster_rule_priority / 10);
                act   = 4'(s.cluster_rule_priority % 10);
                c_hit = (s.cluster_rule_protocol == tirv_pkg::PROTO_ANY) ||
                        (s.cluster_rule_protocol == s.flow_protocol &&
                         (s.cluster_rule_start_port == 16'd0 ||
                          s.flow_dest_port == s.cluster_rule_start_port ||
                          (s.cluster_rule_end_port != 16'd0 &&
                           s.flow_dest_port >= s.cluster_rule_start_port &&
                           s.flow_dest_port <= s.cluster_rule_end_port)));
                if (c_hit && beats(prio, act, admin_prio, admin_act))
                begin
                    admin_prio = prio;
                    admin_act  = act;
                end
                if (c_hit && prio > tirv_pkg::ADMIN_LIMIT &&
                    beats(prio, act, base_prio, base_act))
                begin
                    base_prio = prio;
                    base_act  = act;
                end
            end
            if (s.namespace_list_found && !ns_decided)
            begin
                n_port_hit = (s.namespace_rule_start_port == 16'd0) ||
                             (s.flow_dest_port == s.namespace_rule_start_port) ||
                             (s.flow_dest_port > s.namespace_rule_start_port &&
                              s.flow_dest_port <= s.namespace_rule_end_port);
                if (s.namespace_rule_protocol == tirv_pkg::PROTO_RESERVED)
                begin
                    ns_decided = 1'b1;
                    ns_allows  = 1'b0;
                end
                else if ((s.namespace_rule_protocol == tirv_pkg::PROTO_ANY ||
                          s.namespace_rule_protocol == s.flow_protocol) && n_port_hit)
                begin
                    ns_decided = 1'b1;
                    ns_allows  = 1'b1;
                end
            end
            slot_cnt++;
        end
        if (s.last_slot)
        begin
            verdict_q.push_back(tier_verdict(s.namespace_list_found));
            clear_flow_state();
        end
    endfunction

    // rising edge: check results, fold accepted slots, watchdog
    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        in_fire  = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        if (out_fire)
        begin
            got.allow = m_axis_tdata[0];
            got.tier  = m_axis_tdata[3:1];
            if (verdict_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected verdict word, expected none %s",
                             $time, $sformatf("actual allow=%0d tier=%0d",
                                              got.allow, got.tier));
            end
            else
            begin
                want = verdict_q.pop_front();
                if (got.allow != want.allow)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: allow mismatch, expected %0d actual %0d",
                                 $time, want.allow, got.allow);
                end
                if (got.tier != want.tier)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: decided_tier mismatch, expected %0d actual %0d",
                                 $time, want.tier, got.tier);
                end
            end
        end
        if (in_fire)
            fold_rule_slot(cur_slot);
        if (in_fire || out_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sender: holds a word until taken, then waits its drawn gap
    always @(negedge clk)
    begin
        if (!(s_axis_tvalid && !in_fire))
        begin
            if (in_fire)
                drv_gap = gap_draw(sender_gaps_on);
            if (!rst_n || drv_gap > 0 || slot_queue.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (drv_gap > 0)
                    drv_gap--;
            end
            else
            begin
                cur_slot = slot_queue.pop_front();
                s_axis_tdata  <= pack_slot(cur_slot);
                s_axis_tlast  <= cur_slot.last_slot;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // receiver: drawn stall per word, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (out_fire)
            rcv_gap = gap_draw(receiver_gaps_on);
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rcv_gap > 0)
        begin
            rcv_gap--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic tirv_pkg::slot_t blank_slot(logic [7:0] proto, logic [15:0] port);
        tirv_pkg::slot_t s;
        s = '0;
        s.flow_protocol  = proto;
        s.flow_dest_port = port;
        return s;
    endfunction

    function automatic tirv_pkg::slot_t with_cluster(tirv_pkg::slot_t s, logic [7:0] proto,
                                                     logic [19:0] prio_field,
                                                     logic [15:0] sp, logic [15:0] ep);
        s.cluster_list_found      = 1'b1;
        s.cluster_rule_protocol   = proto;
        s.cluster_rule_priority   = prio_field;
        s.cluster_rule_start_port = sp;
        s.cluster_rule_end_port   = ep;
        return s;
    endfunction

    function automatic tirv_pkg::slot_t with_ns(tirv_pkg::slot_t s, logic [7:0] proto,
                                                logic [15:0] sp, logic [15:0] ep);
        s.namespace_list_found      = 1'b1;
        s.namespace_rule_protocol   = proto;
        s.namespace_rule_start_port = sp;
        s.namespace_rule_end_port   = ep;
        return s;
    endfunction

    function automatic void push_slot(tirv_pkg::slot_t s, bit last);
        s.last_slot = last;
        slot_queue.push_back(s);
    endfunction

    function automatic logic [15:0] start_near(logic [15:0] port);
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return port;
            2: return 16'($urandom_range(port, (port > 40) ? port - 40 : 0));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] end_near(logic [15:0] port);
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return port;
            2: return 16'($urandom_range(port, (port < 65495) ? port + 40 : 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tirv_pkg::slot_t random_slot(logic [7:0] fproto, logic [15:0] fport,
                                                    bit last);
        tirv_pkg::slot_t s;
        int              prio;
        int              act;
        s = blank_slot(fproto, fport);
        s.last_slot = last;
        if ($urandom_range(0, 19) == 0)
        begin
            // noise: entries drawn with no bias toward the flow
            s.cluster_list_found        = 1'($urandom);
            s.cluster_rule_protocol     = 8'($urandom);
            s.cluster_rule_priority     = 20'($urandom_range(0, 655359));
            s.cluster_rule_start_port   = 16'($urandom);
            s.cluster_rule_end_port     = 16'($urandom);
            s.namespace_list_found      = 1'($urandom);
            s.namespace_rule_protocol   = 8'($urandom);
            s.namespace_rule_start_port = 16'($urandom);
            s.namespace_rule_end_port   = 16'($urandom);
            return s;
        end
        s.cluster_list_found = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 3))
            0: s.cluster_rule_protocol = tirv_pkg::PROTO_ANY;
            3: s.cluster_rule_protocol = 8'($urandom);
            default: s.cluster_rule_protocol = fproto;
        endcase
        case ($urandom_range(0, 3))
            0: prio = $urandom_range(0, 65535);
            1: prio = $urandom_range(990, 1010);
            2: prio = $urandom_range(0, 20);
            default: prio = $urandom_range(1001, 1100);
        endcase
        act = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 9) : $urandom_range(0, 2);
        s.cluster_rule_priority   = 20'(prio * 10 + act);
        s.cluster_rule_start_port = start_near(fport);
        s.cluster_rule_end_port   = end_near(fport);
        s.namespace_list_found = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0: s.namespace_rule_protocol = tirv_pkg::PROTO_RESERVED;
            1, 2, 3: s.namespace_rule_protocol = tirv_pkg::PROTO_ANY;
            9: s.namespace_rule_protocol = 8'($urandom);
            default: s.namespace_rule_protocol = fproto;
        endcase
        s.namespace_rule_start_port = start_near(fport);
        s.namespace_rule_end_port   = end_near(fport);
        return s;
    endfunction

    task automatic random_flows(int n_items);
        int         sent;
        int         len;
        logic [7:0] proto;
        logic [15:0] port;
        sent = 0;
        while (sent < n_items)
        begin
            // mostly short flows, some running past the slot bound
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 6);
            case ($urandom_range(0, 5))
                0: proto = 8'd6;
                1: proto = 8'd17;
                2: proto = 8'd0;
                3: proto = 8'd255;
                default: proto = 8'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: port = 16'd0;
                1: port = 16'hFFFF;
                2: port = 16'd80;
                default: port = 16'($urandom);
            endcase
            for (int i = 0; i < len; i++)
                slot_queue.push_back(random_slot(proto, port, i == len - 1));
            sent += len;
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (slot_queue.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
    endtask

    // waits for the pipeline to drain, then writes the pod state
    task automatic write_pod_mode(logic [1:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pod_mode = value;
    endtask

    initial
    begin
        tirv_pkg::slot_t b;
        tirv_pkg::slot_t bx;
        logic [1:0]      phase_pod[6];
        phase_pod = '{tirv_pkg::POD_APPLIED, tirv_pkg::POD_DEFAULT_DENY,
                      tirv_pkg::POD_DEFAULT_ALLOW, tirv_pkg::POD_DEFAULT_DENY,
                      tirv_pkg::POD_APPLIED, tirv_pkg::POD_DEFAULT_ALLOW};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed flows, pod state at its reset value (default allow)
        b = blank_slot(8'd6, 16'd80);
        // admin deny right at the admin limit
        push_slot(with_ns(with_cluster(b, 8'd6, 20'd10000, 16'd80, 16'd0),
                          tirv_pkg::PROTO_RESERVED, 16'd0, 16'd0), 1'b1);
        // equal priority, lower action wins
        push_slot(with_cluster(b, tirv_pkg::PROTO_ANY, 20'd51, 16'd9, 16'd9), 1'b0);
        push_slot(with_ns(with_cluster(b, 8'd6, 20'd50, 16'd0, 16'd0),
                          8'd6, 16'd70, 16'd90), 1'b1);
        // just above the limit: baseline allow via port range
        push_slot(with_cluster(b, 8'd6, 20'd10011, 16'd70, 16'd90), 1'b1);
        // admin pass falls through to namespace allow
        push_slot(with_cluster(b, 8'd6, 20'd2, 16'd0, 16'd0), 1'b0);
        push_slot(with_ns(b, tirv_pkg::PROTO_ANY, 16'd0, 16'd0), 1'b1);
        // cluster list missing: a matching deny entry is ignored
        bx = b;
        bx.cluster_rule_protocol = tirv_pkg::PROTO_ANY;
        push_slot(bx, 1'b1);
        // baseline action outside deny/allow/pass drops silently
        push_slot(with_cluster(b, 8'd6, 20'd20007, 16'd80, 16'd0), 1'b1);
        // all-ones extremes, reserved namespace protocol decides deny first
        bx = blank_slot(8'hFF, 16'hFFFF);
        push_slot(with_ns(with_cluster(bx, 8'hFF, 20'd655359, 16'hFFFF, 16'hFFFF),
                          tirv_pkg::PROTO_RESERVED, 16'hFFFF, 16'hFFFF), 1'b0);
        push_slot(with_ns(bx, tirv_pkg::PROTO_ANY, 16'd0, 16'd0), 1'b1);
        // all-zero extremes
        bx = blank_slot(8'd0, 16'd0);
        push_slot(with_ns(with_cluster(bx, 8'd0, 20'd0, 16'd0, 16'd0),
                          8'd0, 16'd0, 16'd0), 1'b1);
        // first namespace match wins, later reserved entry skipped
        push_slot(with_ns(b, 8'd6, 16'd100, 16'd200), 1'b0);
        push_slot(with_ns(b, 8'd6, 16'd79, 16'd80), 1'b0);
        push_slot(with_ns(b, tirv_pkg::PROTO_RESERVED, 16'd0, 16'd0), 1'b1);
        // single-port cluster entry that misses
        push_slot(with_cluster(b, 8'd6, 20'd10010, 16'd81, 16'd0), 1'b1);

        write_pod_mode(tirv_pkg::POD_APPLIED);
        push_slot(with_cluster(b, 8'd6, 20'd20001, 16'd80, 16'd0), 1'b1);
        push_slot(with_ns(b, 8'd17, 16'd0, 16'd0), 1'b1);

        write_pod_mode(tirv_pkg::POD_DEFAULT_DENY);
        push_slot(b, 1'b1);
        push_slot(with_cluster(b, tirv_pkg::PROTO_ANY, 20'd20000, 16'd5, 16'd5), 1'b1);

        // random phases, each starting idle with a new pod state
        for (int ph = 0; ph < 6; ph++)
        begin
            write_pod_mode(phase_pod[ph]);
            sender_gaps_on   = (ph % 3) != 2;
            receiver_gaps_on = (ph % 3) != 1;
            if (ph == 2)
            begin
                // back-pressure: full-rate sender against a held-off receiver
                sender_gaps_on = 1'b0;
                hold_requests++;
            end
            random_flows(155);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
